// ===== hdl/looping_playhead_advance_defines.svh =====
// ----------------------------------------------------------------------------
// Playhead assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LOOPING_PLAYHEAD_ADVANCE_DEFINES_SVH
`define LOOPING_PLAYHEAD_ADVANCE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define LPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("playhead assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define LPA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("playhead implication failed");
// Consequent must hold in the cycle after the antecedent.
`define LPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("playhead next-cycle check failed");
`else
`define LPA_ASSERT(lbl, prop)
`define LPA_ASSERT_IMPLY(lbl, ante, cons)
`define LPA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/lpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Playhead package
// Widths, opcodes, register indexes and item types shared by the playhead.
// ----------------------------------------------------------------------------
package lpa_pkg;

  // Q1.16 position: one integer bit above the fraction.
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = POS_FRAC_BITS + 1;
  localparam logic [POS_W-1:0] POS_ONE = {1'b1, {POS_FRAC_BITS{1'b0}}};

  localparam int DELTA_W    = 24;
  localparam int DUR_W      = 24;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Dividend of the advance step is delta shifted up by the fraction width.
  localparam int DVD_W = DELTA_W + POS_FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W);

  localparam logic [OP_W-1:0] OP_ADVANCE = 3'd0;
  localparam logic [OP_W-1:0] OP_PLAY    = 3'd1;
  localparam logic [OP_W-1:0] OP_PAUSE   = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
  localparam logic [OP_W-1:0] OP_TRIGGER = 3'd4;
  localparam logic [OP_W-1:0] OP_SEEK    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAY_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [DELTA_W-1:0] delta_samples;
    logic [POS_W-1:0]   seek_position;
  } lpa_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             playing;
  } lpa_result_t;

endpackage

// ===== hdl/lpa_stream_if.sv =====
// ----------------------------------------------------------------------------
// Playhead stream channel
// Valid/ready channel carrying one item payload of a chosen type.
// ----------------------------------------------------------------------------
interface lpa_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== hdl/looping_playhead_advance.sv =====
// Flow: play, pause, stop, trigger, seek and idle advance items pass from
// acceptance through the write state to the result register; a moving
// advance first runs the 40-step bit-serial divider and the fix-up states.
// No item is taken until the last result is registered; stalls delay this.
// Reset (synchronous, rst high): control and config registers return to their
// defaults, the position goes to 0 and playback stops. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Looping playhead advance
// Sampler playhead in Q1.16 with play/pause/stop/trigger/seek and a serial
// divide-and-wrap advance path.
// ----------------------------------------------------------------------------
`include "looping_playhead_advance_defines.svh"

module looping_playhead_advance
  import lpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lpa_stream_if.sink            cmd,
  lpa_stream_if.source          result
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FIX1  = 3'd2;
  localparam logic [2:0] S_FIX2  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  // The position and loop-start reducers only need the last POS_W steps of
  // the divider run; leading zeros would not change their remainder anyway.
  localparam logic [CNT_W-1:0] TAIL_START = CNT_W'(DVD_W - POS_W);
  localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(DVD_W - 1);

  // Configuration registers.
  logic [DUR_W-1:0] duration_samples;
  logic [POS_W-1:0] loop_start;
  logic [POS_W-1:0] loop_end;
  logic [POS_W-1:0] play_start;
  logic             one_shot;

  // Playhead state.
  logic [POS_W-1:0] play_position;
  logic             running;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] pc_sh;
  logic [POS_W-1:0] ls_sh;
  logic [POS_W-1:0] ym;

  logic        res_valid;
  lpa_result_t res_data;

  // Derived loop window and clamped operands. The user must change configuration
  // only while the block is idle (not enforced here), so these are stable through an item.
  logic [POS_W-1:0] ls_c;
  logic [POS_W-1:0] le_clamp;
  logic [POS_W-1:0] le_c;
  logic [POS_W-1:0] w_c;
  logic [POS_W-1:0] ps_c;
  logic [POS_W-1:0] pc_c;
  logic [POS_W-1:0] seek_c;
  logic [POS_W-1:0] trig_pos;

  always_comb begin
    ls_c     = (loop_start >= POS_ONE) ? (POS_ONE - 1'b1) : loop_start;
    le_clamp = (loop_end > POS_ONE) ? POS_ONE : loop_end;
    le_c     = (le_clamp <= ls_c) ? (ls_c + 1'b1) : le_clamp;
    w_c      = le_c - ls_c;
    ps_c     = (play_start > POS_ONE) ? POS_ONE : play_start;
    pc_c     = (play_position > POS_ONE) ? POS_ONE : play_position;
    seek_c   = (cmd.payload.seek_position > POS_ONE) ? POS_ONE
                                                     : cmd.payload.seek_position;
    trig_pos = (ps_c >= le_c) ? ls_c : ps_c;
  end

  // Handshake: the input side is open only between items, while the result
  // register on the output side lets a finished item wait for its consumer.
  logic cmd_fire;
  logic out_free;

  assign cmd.ready    = (state == S_IDLE);
  assign cmd_fire     = cmd.valid && cmd.ready;
  assign out_free     = !res_valid || result.ready;
  assign result.valid = res_valid;
  assign result.payload = res_data;

  // An advance only moves when playing with nonzero delta and duration.
  logic adv_active;
  assign adv_active = running && (cmd.payload.delta_samples != '0) &&
                      (duration_samples != '0);

  // Serial datapath. The divider computes delta * 2^16 / duration one
  // quotient bit per cycle. Each quotient bit is also streamed into a modulo
  // reducer, so the quotient modulo the window width is ready when the
  // divide ends. Two more reducers fold the current position and the loop
  // start modulo the width over the last 17 steps of the same run.
  logic             div_step;
  logic             tail_step;
  logic             qbit;
  logic [DVD_W-1:0] quotient;
  logic [POS_W-1:0] qm;
  logic [POS_W-1:0] pcm;
  logic [POS_W-1:0] lm;

  assign div_step  = (state == S_DIV);
  assign tail_step = div_step && (cnt >= TAIL_START);

  lpa_div u_div (
    .clk      (clk),
    .load     (cmd_fire),
    .step     (div_step),
    .delta    (cmd.payload.delta_samples),
    .divisor  (duration_samples),
    .qbit     (qbit),
    .quotient (quotient)
  );

  lpa_modser u_mod_q (
    .clk     (clk),
    .clear   (cmd_fire),
    .step    (div_step),
    .din     (qbit),
    .modulus (w_c),
    .rem     (qm)
  );

  lpa_modser u_mod_pos (
    .clk     (clk),
    .clear   (cmd_fire),
    .step    (tail_step),
    .din     (pc_sh[POS_W-1]),
    .modulus (w_c),
    .rem     (pcm)
  );

  lpa_modser u_mod_ls (
    .clk     (clk),
    .clear   (cmd_fire),
    .step    (tail_step),
    .din     (ls_sh[POS_W-1]),
    .modulus (w_c),
    .rem     (lm)
  );

  // First fix-up: (pos mod w + q mod w) mod w, a single conditional subtract
  // because both terms are below w.
  logic [POS_W:0]   ym_sum;
  logic [POS_W:0]   ym_red;
  logic [POS_W-1:0] ym_next;

  always_comb begin
    ym_sum  = {1'b0, pcm} + {1'b0, qm};
    ym_red  = ym_sum - {1'b0, w_c};
    ym_next = (ym_sum >= {1'b0, w_c}) ? ym_red[POS_W-1:0] : ym_sum[POS_W-1:0];
  end

  // Second fix-up. Looping: the new position is ls + ((p - ls) mod w), which
  // covers both the above-start and below-start wrap. One-shot: add the full
  // quotient and clamp at 1.0, which also stops playback.
  logic [POS_W:0]   lp_diff;
  logic [POS_W:0]   lp_wrap;
  logic [POS_W-1:0] lp_off;
  logic [POS_W:0]   os_sum;
  logic             os_end;
  logic [POS_W-1:0] pos_next;
  logic             running_next;

  always_comb begin
    lp_diff = {1'b0, ym} - {1'b0, lm};
    lp_wrap = lp_diff + {1'b0, w_c};
    lp_off  = lp_diff[POS_W] ? lp_wrap[POS_W-1:0] : lp_diff[POS_W-1:0];
    os_sum  = {1'b0, pc_c} + {1'b0, quotient[POS_W-1:0]};
    os_end  = (quotient[DVD_W-1:POS_W] != '0) || (os_sum >= {1'b0, POS_ONE});
    if (one_shot) begin
      pos_next     = os_end ? POS_ONE : os_sum[POS_W-1:0];
      running_next = !os_end;
    end else begin
      pos_next     = ls_c + lp_off;
      running_next = 1'b1;
    end
  end

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_samples <= '0;
      loop_start       <= '0;
      loop_end         <= POS_ONE;
      play_start       <= '0;
      one_shot         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DURATION:   duration_samples <= cfg_data[DUR_W-1:0];
        REG_LOOP_START: loop_start       <= cfg_data[POS_W-1:0];
        REG_LOOP_END:   loop_end         <= cfg_data[POS_W-1:0];
        REG_PLAY_START: play_start       <= cfg_data[POS_W-1:0];
        REG_ONE_SHOT:   one_shot         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and playhead state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      play_position <= '0;
      running       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            state <= ((cmd.payload.opcode == OP_ADVANCE) && adv_active) ? S_DIV
                                                                         : S_WRITE;
            cnt   <= '0;
            case (cmd.payload.opcode)
              // A moving advance runs the divider; an idle one only reports.
              OP_ADVANCE: ;
              OP_PLAY:  running <= 1'b1;
              OP_PAUSE: running <= 1'b0;
              OP_STOP: begin
                running       <= 1'b0;
                play_position <= '0;
              end
              OP_TRIGGER: begin
                play_position <= trig_pos;
                running       <= 1'b1;
              end
              OP_SEEK: play_position <= seek_c;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= S_FIX1;
          end
        end
        S_FIX1: state <= S_FIX2;
        S_FIX2: begin
          play_position <= pos_next;
          running       <= running_next;
          state         <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operand shift registers feeding the position and loop-start reducers.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      pc_sh <= pc_c;
      ls_sh <= ls_c;
    end else if (tail_step) begin
      pc_sh <= {pc_sh[POS_W-2:0], 1'b0};
      ls_sh <= {ls_sh[POS_W-2:0], 1'b0};
    end
    if (state == S_FIX1) begin
      ym <= ym_next;
    end
  end

  // Result register: loaded once per item from the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if ((state == S_WRITE) && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WRITE) && out_free) begin
      res_data.position <= play_position;
      res_data.playing  <= running;
    end
  end

  // The stored position never exceeds 1.0.
  `LPA_ASSERT(a_pos_range, play_position <= POS_ONE)
  // All three serial remainders are fully reduced when the divide ends.
  `LPA_ASSERT_IMPLY(a_rem_reduced, state == S_FIX1, (qm < w_c) && (pcm < w_c) && (lm < w_c))
  // A looping advance lands inside the loop window.
  `LPA_ASSERT_NEXT(a_loop_window, (state == S_FIX2) && !one_shot, (play_position >= ls_c) && (play_position < le_c))
  // A one-shot advance that stops playback leaves the position at 1.0.
  `LPA_ASSERT_NEXT(a_oneshot_end, (state == S_FIX2) && one_shot && os_end, (play_position == POS_ONE) && !running)

endmodule

// ===== hdl/lpa_div.sv =====
// ----------------------------------------------------------------------------
// Playhead bit-serial divider
// Restoring divider producing one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module lpa_div
  import lpa_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic [DELTA_W-1:0] delta,
  input  logic [DUR_W-1:0]   divisor,
  output logic               qbit,
  output logic [DVD_W-1:0]   quotient
);

  logic [DUR_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [DUR_W:0]   trial;
  logic [DUR_W:0]   diff;

  // The dividend register fills with quotient bits from the bottom as it
  // shifts out, so after all steps it holds the quotient.
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvd <= {delta, {POS_FRAC_BITS{1'b0}}};
    end else if (step) begin
      rem <= qbit ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

  assign quotient = dvd;

endmodule

// ===== hdl/lpa_modser.sv =====
// ----------------------------------------------------------------------------
// Playhead serial modulo reducer
// Keeps the remainder of a bit stream, MSB first, modulo the window width.
// ----------------------------------------------------------------------------
module lpa_modser
  import lpa_pkg::*;
(
  input  logic             clk,
  input  logic             clear,
  input  logic             step,
  input  logic             din,
  input  logic [POS_W-1:0] modulus,
  output logic [POS_W-1:0] rem
);

  logic [POS_W:0] trial;
  logic [POS_W:0] diff;
  logic [POS_W:0] red;

  // rem < modulus, so 2*rem + din < 2*modulus and one subtract suffices.
  always_comb begin
    trial = {rem, din};
    diff  = trial - {1'b0, modulus};
    red   = (trial >= {1'b0, modulus}) ? diff : trial;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      rem <= '0;
    end else if (step) begin
      rem <= red[POS_W-1:0];
    end
  end

endmodule
